@@ rtl/fcs_pkg.sv @@
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types and command codes for the flash command sequencer.
// ----------------------------------------------------------------------------
package fcs_pkg;

  // Bus unlock addresses and data
  localparam logic [15:0] ADDR_UNLOCK1 = 16'h5555;
  localparam logic [15:0] ADDR_UNLOCK2 = 16'h2AAA;
  localparam logic [7:0]  DATA_UNLOCK1 = 8'hAA;
  localparam logic [7:0]  DATA_UNLOCK2 = 8'h55;

  // Command bytes
  localparam logic [7:0] CMD_AUTOSEL = 8'h90;
  localparam logic [7:0] CMD_ERASE   = 8'h80;
  localparam logic [7:0] CMD_RESET   = 8'hF0;
  localparam logic [7:0] CMD_PROGRAM = 8'hA0;
  localparam logic [7:0] CMD_BANK    = 8'hB0;
  localparam logic [7:0] CMD_SECTOR  = 8'h30;
  localparam logic [7:0] CMD_CHIP    = 8'h10;

  // Autoselect IDs
  localparam logic [7:0] MAN_ID_SMALL = 8'h32;
  localparam logic [7:0] DEV_ID_SMALL = 8'h1B;
  localparam logic [7:0] MAN_ID_LARGE = 8'h62;
  localparam logic [7:0] DEV_ID_LARGE = 8'h13;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    SW_INIT,
    SW_SECTOR,
    SW_CHIP
  } sweep_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic        rd_en;        // array read at the accepted address
    logic        wr_en;        // byte program at the accepted address
    logic        sweep_start;  // launch a fill sweep
    sweep_kind_t sweep_kind;
    logic        bank;         // current bank select
    logic        out_load;     // load the result register
    logic        out_from_mem; // take the result from the array read word
    logic [7:0]  out_byte;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;          // last fill write happens this cycle
  } dp_status_t;

endpackage

@@ rtl/fcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcs_ctrl
// Command sequencer, read mode, bank select and handshake control.
// ----------------------------------------------------------------------------
module fcs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_command,
  input  logic [15:0]          in_address,
  input  logic [7:0]           in_write_data,
  input  logic                 large_size,
  input  fcs_pkg::dp_status_t  status,
  output fcs_pkg::dp_cmd_t     cmd,
  output logic                 busy,
  output logic                 out_valid
);
  import fcs_pkg::*;

  typedef enum logic [1:0] {
    PH_INIT,
    PH_IDLE,
    PH_RDWAIT,
    PH_SWEEP
  } phase_t;

  typedef enum logic [3:0] {
    SQ_IDLE    = 4'd0,
    SQ_UNLK1   = 4'd1,
    SQ_UNLK2   = 4'd2,
    SQ_AUTOSEL = 4'd3,
    SQ_ERS1    = 4'd4,
    SQ_ERS2    = 4'd5,
    SQ_ERSCMD  = 4'd6,
    SQ_PROG    = 4'd8,
    SQ_BANK    = 4'd9
  } seq_t;

  typedef enum logic [1:0] {
    RM_ARRAY   = 2'd0,
    RM_AUTOSEL = 2'd1,
    RM_ERASED  = 2'd2
  } rmode_t;

  phase_t phase_r, phase_nxt;
  seq_t   seq_r, seq_nxt;
  rmode_t rmode_r, rmode_nxt;
  logic   bank_r, bank_nxt;
  logic   busy_r, valid_r, valid_nxt;
  logic   accept;
  logic   is_unlock1, is_unlock2;

  assign accept     = start && !busy_r;
  assign is_unlock1 = (in_address == ADDR_UNLOCK1) && (in_write_data == DATA_UNLOCK1);
  assign is_unlock2 = (in_address == ADDR_UNLOCK2) && (in_write_data == DATA_UNLOCK2);

  always_comb begin
    phase_nxt = phase_r;
    seq_nxt   = seq_r;
    rmode_nxt = rmode_r;
    bank_nxt  = bank_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    cmd.sweep_kind = SW_INIT;
    cmd.bank  = bank_r;

    case (phase_r)
      PH_INIT: begin
        cmd.sweep_start = 1'b1;
        cmd.sweep_kind  = SW_INIT;
        phase_nxt       = PH_SWEEP;
      end
      PH_RDWAIT: begin
        valid_nxt        = 1'b1;
        cmd.out_load     = 1'b1;
        cmd.out_from_mem = 1'b1;
        phase_nxt        = PH_IDLE;
      end
      PH_SWEEP: begin
        if (status.sweep_last) phase_nxt = PH_IDLE;
      end
      PH_IDLE: begin
        if (accept && !in_command) begin
          // bus read
          case (rmode_r)
            RM_ARRAY: begin
              cmd.rd_en = 1'b1;
              phase_nxt = PH_RDWAIT;
            end
            RM_AUTOSEL: begin
              valid_nxt    = 1'b1;
              cmd.out_load = 1'b1;
              if (in_address[7:0] == 8'd0)
                cmd.out_byte = large_size ? MAN_ID_LARGE : MAN_ID_SMALL;
              else if (in_address[7:0] == 8'd1)
                cmd.out_byte = large_size ? DEV_ID_LARGE : DEV_ID_SMALL;
              else
                cmd.out_byte = 8'd0;
            end
            RM_ERASED: begin
              valid_nxt    = 1'b1;
              cmd.out_load = 1'b1;
              cmd.out_byte = ERASED_BYTE;
              seq_nxt      = SQ_IDLE;
              rmode_nxt    = RM_ARRAY;
            end
            default: begin
              valid_nxt    = 1'b1;
              cmd.out_load = 1'b1;
            end
          endcase
        end else if (accept) begin
          // bus write: result is always zero
          valid_nxt    = 1'b1;
          cmd.out_load = 1'b1;
          case (seq_r)
            SQ_IDLE: begin
              if (is_unlock1) seq_nxt = SQ_UNLK1;
            end
            SQ_UNLK1: begin
              seq_nxt = is_unlock2 ? SQ_UNLK2 : SQ_IDLE;
            end
            SQ_UNLK2: begin
              if (in_address != ADDR_UNLOCK1) begin
                seq_nxt = SQ_IDLE; rmode_nxt = RM_ARRAY;
              end else if (in_write_data == CMD_AUTOSEL) begin
                seq_nxt = SQ_AUTOSEL; rmode_nxt = RM_AUTOSEL;
              end else if (in_write_data == CMD_ERASE) begin
                seq_nxt = SQ_ERS1;
              end else if (in_write_data == CMD_PROGRAM) begin
                seq_nxt = SQ_PROG;
              end else if (in_write_data == CMD_BANK && large_size) begin
                seq_nxt = SQ_BANK;
              end else begin
                seq_nxt = SQ_IDLE; rmode_nxt = RM_ARRAY;
              end
            end
            SQ_ERS1: begin
              if (is_unlock1) seq_nxt = SQ_ERS2;
              else begin
                seq_nxt = SQ_IDLE; rmode_nxt = RM_ARRAY;
              end
            end
            SQ_ERS2: begin
              if (is_unlock2) seq_nxt = SQ_ERSCMD;
              else begin
                seq_nxt = SQ_IDLE; rmode_nxt = RM_ARRAY;
              end
            end
            SQ_ERSCMD: begin
              // stay here after an erase; the next read clears the sequencer
              if (in_write_data == CMD_SECTOR) begin
                cmd.sweep_start = 1'b1;
                cmd.sweep_kind  = SW_SECTOR;
                rmode_nxt       = RM_ERASED;
                phase_nxt       = PH_SWEEP;
              end else if (in_write_data == CMD_CHIP) begin
                cmd.sweep_start = 1'b1;
                cmd.sweep_kind  = SW_CHIP;
                rmode_nxt       = RM_ERASED;
                phase_nxt       = PH_SWEEP;
              end else begin
                seq_nxt = SQ_IDLE; rmode_nxt = RM_ARRAY;
              end
            end
            SQ_AUTOSEL: begin
              if (in_write_data == CMD_RESET) begin
                seq_nxt = SQ_IDLE; rmode_nxt = RM_ARRAY;
              end else if (is_unlock1) begin
                seq_nxt = SQ_UNLK1;
              end else begin
                seq_nxt = SQ_IDLE; rmode_nxt = RM_ARRAY;
              end
            end
            SQ_PROG: begin
              cmd.wr_en = 1'b1;
              seq_nxt   = SQ_IDLE;
              rmode_nxt = RM_ARRAY;
            end
            SQ_BANK: begin
              if (in_address == 16'd0) bank_nxt = in_write_data[0];
              seq_nxt   = SQ_IDLE;
              rmode_nxt = RM_ARRAY;
            end
            default: begin
            end
          endcase
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_INIT;
      seq_r   <= SQ_IDLE;
      rmode_r <= RM_ARRAY;
      bank_r  <= 1'b0;
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      seq_r   <= seq_nxt;
      rmode_r <= rmode_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= (phase_nxt != PH_IDLE);
      valid_r <= valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = valid_r;

endmodule

@@ rtl/fcs_datapath.sv @@
// ----------------------------------------------------------------------------
// fcs_datapath
// Flash array, address formation, fill sweep engine and result register.
// ----------------------------------------------------------------------------
module fcs_datapath #(
  parameter int BANK_BYTES   = 65536,
  parameter int SECTOR_BYTES = 4096,
  parameter int NUM_BANKS    = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fcs_pkg::dp_cmd_t    cmd,
  input  logic [15:0]         in_address,
  input  logic [7:0]          in_write_data,
  input  logic                large_size,
  input  logic [7:0]          erase_fill,
  output fcs_pkg::dp_status_t status,
  output logic [7:0]          out_read_data
);
  import fcs_pkg::*;

  localparam int MEM_DEPTH  = NUM_BANKS * BANK_BYTES;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);
  localparam int BANK_AW    = $clog2(BANK_BYTES);
  localparam int ERASE_SPAN = (SECTOR_BYTES < BANK_BYTES) ? SECTOR_BYTES : BANK_BYTES;
  localparam int LW         = MEM_AW + 1;
  localparam logic [BANK_AW-1:0] SEC_MASK = ~(BANK_AW'(ERASE_SPAN - 1));

  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        mem_q_r;
  logic [7:0]        out_r;
  logic              bank_eff;
  logic [MEM_AW-1:0] arr_addr, sec_base;
  logic              sweep_act_r;
  logic [MEM_AW-1:0] sweep_addr_r;
  logic [LW-1:0]     sweep_left_r;
  logic [7:0]        sweep_fill_r;
  logic [LW-1:0]     chip_len;

  // bank select has no effect on a single-bank device
  assign bank_eff = (NUM_BANKS > 1) ? cmd.bank : 1'b0;
  assign arr_addr = MEM_AW'({bank_eff, in_address[BANK_AW-1:0]});
  assign sec_base = MEM_AW'({bank_eff, in_address[BANK_AW-1:0] & SEC_MASK});
  assign chip_len = large_size ? LW'(MEM_DEPTH) : LW'(BANK_BYTES);

  assign status.sweep_last = sweep_act_r && (sweep_left_r == LW'(1));

  // Sweep engine: one fill write per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_act_r <= 1'b0;
    end else if (cmd.sweep_start) begin
      sweep_act_r <= 1'b1;
    end else if (status.sweep_last) begin
      sweep_act_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      case (cmd.sweep_kind)
        SW_SECTOR: begin
          sweep_addr_r <= sec_base;
          sweep_left_r <= LW'(ERASE_SPAN);
          sweep_fill_r <= erase_fill;
        end
        SW_CHIP: begin
          sweep_addr_r <= '0;
          sweep_left_r <= chip_len;
          sweep_fill_r <= erase_fill;
        end
        default: begin
          sweep_addr_r <= '0;
          sweep_left_r <= LW'(MEM_DEPTH);
          sweep_fill_r <= ERASED_BYTE;
        end
      endcase
    end else if (sweep_act_r) begin
      sweep_addr_r <= sweep_addr_r + MEM_AW'(1);
      sweep_left_r <= sweep_left_r - LW'(1);
    end
  end

  // Array: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (sweep_act_r) begin
      mem[sweep_addr_r] <= sweep_fill_r;
    end else if (cmd.wr_en) begin
      mem[arr_addr] <= in_write_data;
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[arr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= cmd.out_from_mem ? mem_q_r : cmd.out_byte;
    end
  end

  assign out_read_data = out_r;

endmodule

@@ rtl/flash_command_sequencer.sv @@
// ----------------------------------------------------------------------------
// flash_command_sequencer
// Byte-wide parallel flash save device driven by bus read and write words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a word (in_command, in_address, in_write_data) is taken at
//   a clock edge with start high and busy low. Every word yields exactly one
//   result word on out_read_data, marked by out_valid for one cycle; the
//   receiver has no way to hold it off, so sample it when out_valid is high.
//   Result path: an array read passes the registered array read port and then
//   the result register and keeps busy high for one cycle; every other word
//   returns through the result register in the cycle after acceptance and
//   allows a new word on the next cycle.
//   Erase: the result of a sector or chip erase write comes out at once, then
//   busy stays high while the fill engine writes one byte per cycle:
//   min(SECTOR_BYTES, BANK_BYTES) bytes for a sector erase, BANK_BYTES or
//   NUM_BANKS*BANK_BYTES bytes for a chip erase.
//   Reset: rst_n is synchronous. After reset the whole array is cleared to
//   0xFF, one byte per cycle; busy stays high from reset until all
//   NUM_BANKS*BANK_BYTES bytes are written. Config writes (cfg_we,
//   cfg_index, cfg_wdata) are taken at any time but only while idle are
//   they safe. BANK_BYTES and SECTOR_BYTES must be powers of two.
// ----------------------------------------------------------------------------
module flash_command_sequencer #(
  parameter int BANK_BYTES   = 65536,
  parameter int SECTOR_BYTES = 4096,
  parameter int NUM_BANKS    = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  output logic [7:0]  out_read_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import fcs_pkg::*;

  // Register indexes of the config port
  localparam logic REG_LARGE_SIZE = 1'b0;
  localparam logic REG_ERASE_FILL = 1'b1;

  logic       large_size_r;
  logic [7:0] erase_fill_r;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      large_size_r <= 1'b0;
      erase_fill_r <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LARGE_SIZE: large_size_r <= cfg_wdata[0];
        REG_ERASE_FILL: erase_fill_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Sequencer and handshake control
  fcs_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_command    (in_command),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .large_size    (large_size_r),
    .status        (dp_status),
    .cmd           (dp_cmd),
    .busy          (busy),
    .out_valid     (out_valid)
  );

  // Array, fill engine, result register
  fcs_datapath #(
    .BANK_BYTES   (BANK_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES),
    .NUM_BANKS    (NUM_BANKS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .large_size    (large_size_r),
    .erase_fill    (erase_fill_r),
    .status        (dp_status),
    .out_read_data (out_read_data)
  );

  // A bus write always answers with zero on the next cycle
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command) |=> (out_valid && out_read_data == 8'd0))
    else $error("write word did not return zero result");

  // An array read holds off new words, then delivers its result
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.rd_en |=> (busy && !out_valid) ##1 out_valid)
    else $error("array read result timing broken");

  // A launched sweep keeps the block busy
  a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.sweep_start |=> busy)
    else $error("busy low after sweep start");

  // Fill writes never overlap accepted words
  a_sweep_excl: assert property (@(posedge clk) disable iff (!rst_n)
    dp_status.sweep_last |-> (busy && !dp_cmd.wr_en && !dp_cmd.rd_en))
    else $error("sweep overlaps bus access");

endmodule

@@ dv/flash_command_sequencer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_command_sequencer_test
// Drives bus read and write words into the flash command sequencer and checks
// every returned byte against an in-bench copy of the flash array, command
// sequencer and read mode. Directed words cover unlock, program, autoselect,
// erase and bank select. Random traffic then runs under several register
// settings, with random sender gaps in all but the last.
// ----------------------------------------------------------------------------
module flash_command_sequencer_test;
  import fcs_pkg::*;

  localparam int BANK_SIZE   = 65536;
  localparam int SECTOR_SIZE = 4096;
  localparam int BANK_COUNT  = 2;

  // Longest legal silence is the clear after reset or a two-bank chip
  // erase; allow several times that.
  localparam int QUIET_LIMIT = 600000;

  // Register indexes on the cfg port
  localparam logic CFG_LARGE_SIZE = 1'b0;
  localparam logic CFG_ERASE_FILL = 1'b1;

  // Command sequencer states, as the device walks the unlock protocol
  typedef enum logic [3:0] {
    SEQ_IDLE    = 4'd0,
    SEQ_UNLK1   = 4'd1,
    SEQ_UNLK2   = 4'd2,
    SEQ_AUTOSEL = 4'd3,
    SEQ_ERS1    = 4'd4,
    SEQ_ERS2    = 4'd5,
    SEQ_ERSCMD  = 4'd6,
    SEQ_PROG    = 4'd8,
    SEQ_BANK    = 4'd9
  } seq_state_t;

  // What a bus read returns
  typedef enum logic [1:0] {
    RD_ARRAY   = 2'd0,
    RD_AUTOSEL = 2'd1,
    RD_ERASED  = 2'd2
  } read_mode_t;

  typedef struct {
    logic        is_write;
    logic [15:0] addr;
    logic [7:0]  data;
  } bus_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_command = 1'b0;
  logic [15:0] in_address = 16'h0000;
  logic [7:0]  in_write_data = 8'h00;
  logic        out_valid;
  logic [7:0]  out_read_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;

  // In-bench copy of the device
  logic [7:0]  flash_mem [0:BANK_COUNT*BANK_SIZE-1];
  seq_state_t  seq_st;
  read_mode_t  rd_mode;
  logic        bank_sel;
  logic        cfg_large;
  logic [7:0]  cfg_fill;

  // Bytes the device owes us, oldest first
  bus_result_t expected_bytes[$];
  bus_result_t oldest;

  int          fail_count = 0;
  int          words_sent = 0;
  int          quiet_cycles = 0;
  int          chip_erase_budget = 2;
  logic        gaps_on = 1'b1;

  flash_command_sequencer #(
    .BANK_BYTES   (BANK_SIZE),
    .SECTOR_BYTES (SECTOR_SIZE),
    .NUM_BANKS    (BANK_COUNT)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Device behavior
  // ------------------------------------------------------------------------

  task automatic back_to_array();
    seq_st  = SEQ_IDLE;
    rd_mode = RD_ARRAY;
  endtask

  task automatic fill_range(input int first, input int count);
    for (int i = first; i < first + count; i++) flash_mem[i] = cfg_fill;
  endtask

  // Apply one bus word to the in-bench device and return the byte it yields
  task automatic flash_access(input logic is_write, input logic [15:0] addr,
                              input logic [7:0] wd, output logic [7:0] rd);
    int base;
    int sector_start;
    int sector_len;
    rd = 8'h00;
    base = int'(bank_sel) * BANK_SIZE;
    if (!is_write) begin
      case (rd_mode)
        RD_ARRAY: begin
          rd = flash_mem[base + int'(addr)];
        end
        RD_AUTOSEL: begin
          // only offsets 0 and 1 carry an ID; the rest read as zero
          if (addr[7:0] == 8'h00) rd = cfg_large ? MAN_ID_LARGE : MAN_ID_SMALL;
          else if (addr[7:0] == 8'h01) rd = cfg_large ? DEV_ID_LARGE : DEV_ID_SMALL;
        end
        RD_ERASED: begin
          // one status read after an erase, then back to the array
          rd = ERASED_BYTE;
          back_to_array();
        end
        default: begin
          rd = 8'h00;
        end
      endcase
    end else begin
      case (seq_st)
        SEQ_IDLE: begin
          if (addr == ADDR_UNLOCK1 && wd == DATA_UNLOCK1) seq_st = SEQ_UNLK1;
        end
        SEQ_UNLK1: begin
          // a bad second unlock drops the sequence but keeps the read mode
          seq_st = (addr == ADDR_UNLOCK2 && wd == DATA_UNLOCK2) ? SEQ_UNLK2 : SEQ_IDLE;
        end
        SEQ_UNLK2: begin
          if (addr != ADDR_UNLOCK1) begin
            back_to_array();
          end else if (wd == CMD_AUTOSEL) begin
            seq_st  = SEQ_AUTOSEL;
            rd_mode = RD_AUTOSEL;
          end else if (wd == CMD_ERASE) begin
            seq_st = SEQ_ERS1;
          end else if (wd == CMD_PROGRAM) begin
            seq_st = SEQ_PROG;
          end else if (wd == CMD_BANK && cfg_large) begin
            seq_st = SEQ_BANK;
          end else begin
            back_to_array();
          end
        end
        SEQ_ERS1: begin
          if (addr == ADDR_UNLOCK1 && wd == DATA_UNLOCK1) seq_st = SEQ_ERS2;
          else back_to_array();
        end
        SEQ_ERS2: begin
          if (addr == ADDR_UNLOCK2 && wd == DATA_UNLOCK2) seq_st = SEQ_ERSCMD;
          else back_to_array();
        end
        SEQ_ERSCMD: begin
          // stay here after an erase: a sector or chip code is decoded as an erase
          if (wd == CMD_SECTOR) begin
            sector_start = int'(addr) & ~(SECTOR_SIZE - 1);
            sector_len = (SECTOR_SIZE < BANK_SIZE - sector_start) ?
                         SECTOR_SIZE : BANK_SIZE - sector_start;
            fill_range(base + sector_start, sector_len);
            rd_mode = RD_ERASED;
          end else if (wd == CMD_CHIP) begin
            // 64 KB mode clears bank 0 only, whatever bank is selected
            fill_range(0, cfg_large ? BANK_COUNT * BANK_SIZE : BANK_SIZE);
            rd_mode = RD_ERASED;
          end else begin
            back_to_array();
          end
        end
        SEQ_AUTOSEL: begin
          if (wd == CMD_RESET) back_to_array();
          else if (addr == ADDR_UNLOCK1 && wd == DATA_UNLOCK1) seq_st = SEQ_UNLK1;
          else back_to_array();
        end
        SEQ_PROG: begin
          flash_mem[base + int'(addr)] = wd;
          back_to_array();
        end
        SEQ_BANK: begin
          if (addr == 16'h0000) bank_sel = wd[0];
          back_to_array();
        end
        default: begin
        end
      endcase
    end
  endtask

  // ------------------------------------------------------------------------
  // Word driving
  // ------------------------------------------------------------------------

  task automatic report_failure(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Drop start; the argument n sets how long it stays low
  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Present one word, wait for the device to take it, then predict its byte.
  // Start is left high; the next word or a hold-off decides what follows.
  task automatic send_word(input logic is_write, input logic [15:0] addr,
                           input logic [7:0] wd);
    bus_result_t want;
    if (gaps_on && $urandom_range(0, 99) < 15) hold_off($urandom_range(1, 14));
    @(negedge clk);
    start         <= 1'b1;
    in_command    <= is_write;
    in_address    <= addr;
    in_write_data <= wd;
    do @(posedge clk); while (busy !== 1'b0);
    want.is_write = is_write;
    want.addr     = addr;
    flash_access(is_write, addr, wd, want.data);
    expected_bytes.push_back(want);
    words_sent++;
  endtask

  // Stop sending and wait for every outstanding byte
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Write both registers once the device is fully idle (erase sweeps done)
  task automatic program_registers(input logic two_banks, input logic [7:0] fill_byte);
    drain_results();
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LARGE_SIZE;
    cfg_wdata <= {7'b0, two_banks};
    @(negedge clk);
    cfg_index <= CFG_ERASE_FILL;
    cfg_wdata <= fill_byte;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_large = two_banks;
    cfg_fill  = fill_byte;
  endtask

  task automatic unlock_pair();
    send_word(1'b1, ADDR_UNLOCK1, DATA_UNLOCK1);
    send_word(1'b1, ADDR_UNLOCK2, DATA_UNLOCK2);
  endtask

  task automatic command_prefix(input logic [7:0] code);
    unlock_pair();
    send_word(1'b1, ADDR_UNLOCK1, code);
  endtask

  task automatic erase_chain(input logic [7:0] code, input logic [15:0] addr);
    command_prefix(CMD_ERASE);
    unlock_pair();
    send_word(1'b1, addr, code);
  endtask

  // Mostly a small hot set so programmed bytes get read back
  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 5))
      0, 1: begin
        return 16'($urandom);
      end
      2: begin
        return 16'hFFFF - 16'($urandom_range(0, 3));
      end
      default: begin
        return {4'($urandom), 8'h00, 4'($urandom_range(0, 7))};
      end
    endcase
  endfunction

  // Keep noise from launching an erase when an erase is pending
  function automatic logic [7:0] defuse(input logic [7:0] d);
    if (seq_st == SEQ_ERSCMD && (d == CMD_SECTOR || d == CMD_CHIP)) return d ^ 8'h01;
    return d;
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  task automatic test_power_up_read();
    // array comes out of reset erased
    send_word(1'b0, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_byte_program();
    command_prefix(CMD_PROGRAM);
    send_word(1'b1, 16'hFFFF, 8'h00);
    send_word(1'b0, 16'hFFFF, 8'h00);
  endtask

  task automatic test_autoselect();
    command_prefix(CMD_AUTOSEL);
    send_word(1'b0, 16'h0000, 8'h00);
    send_word(1'b0, 16'hFF01, 8'h00);
    // broken second unlock: sequencer drops, autoselect read mode stays
    send_word(1'b1, ADDR_UNLOCK1, DATA_UNLOCK1);
    send_word(1'b1, ADDR_UNLOCK2, DATA_UNLOCK1);
    send_word(1'b0, 16'h1202, 8'h00);
    // bank select is not a command in 64 KB mode: full drop to array
    command_prefix(CMD_BANK);
    send_word(1'b0, 16'hFFFF, 8'h00);
  endtask

  task automatic test_sector_erase();
    // top sector, fill still at its reset value
    erase_chain(CMD_SECTOR, 16'hF123);
    send_word(1'b0, 16'hF456, 8'h00);
  endtask

  task automatic test_two_bank_chip_erase();
    command_prefix(CMD_BANK);
    send_word(1'b1, 16'h0000, 8'h01);
    erase_chain(CMD_CHIP, 16'h0000);
    send_word(1'b0, 16'h8000, 8'h00);
    send_word(1'b0, 16'h8000, 8'h00);
  endtask

  task automatic test_random_traffic(input int n_words);
    int          stop_at;
    int          pick;
    int          len;
    int          k;
    int          last;
    logic [15:0] a;
    logic [15:0] seq_addr [0:5];
    logic [7:0]  seq_data [0:5];
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        // program, usually read straight back
        a = pick_address();
        command_prefix(CMD_PROGRAM);
        send_word(1'b1, a, 8'($urandom));
        if ($urandom_range(0, 3) != 0) send_word(1'b0, a, 8'($urandom));
      end else if (pick < 46) begin
        repeat ($urandom_range(1, 4)) send_word(1'b0, pick_address(), 8'($urandom));
      end else if (pick < 56) begin
        command_prefix(CMD_AUTOSEL);
        repeat ($urandom_range(1, 3)) begin
          a = pick_address();
          case ($urandom_range(0, 2))
            0: a[7:0] = 8'h00;
            1: a[7:0] = 8'h01;
            default: ;
          endcase
          send_word(1'b0, a, 8'($urandom));
        end
        // leave by reset, by a stray write, or not at all
        case ($urandom_range(0, 2))
          0: send_word(1'b1, pick_address(), CMD_RESET);
          1: send_word(1'b1, pick_address(), 8'($urandom));
          default: ;
        endcase
      end else if (pick < 61) begin
        command_prefix(CMD_BANK);
        a = ($urandom_range(0, 3) == 0) ? pick_address() : 16'h0000;
        send_word(1'b1, a, 8'($urandom));
      end else if (pick < 66) begin
        erase_chain(CMD_SECTOR, pick_address());
        // a pending erase decodes an erase code as another erase, other data drops it
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1) == 0) send_word(1'b1, pick_address(), CMD_SECTOR);
          else send_word(1'b1, pick_address(), defuse(8'($urandom)));
        end
        send_word(1'b0, pick_address(), 8'($urandom));
      end else if (pick < 68 && chip_erase_budget > 0) begin
        chip_erase_budget--;
        erase_chain(CMD_CHIP, pick_address());
        send_word(1'b0, pick_address(), 8'($urandom));
      end else if (pick < 84) begin
        // well-formed command with one bit flipped, possibly cut short
        for (int i = 0; i < 6; i++) begin
          seq_addr[i] = ADDR_UNLOCK1;
          seq_data[i] = DATA_UNLOCK1;
        end
        seq_addr[1] = ADDR_UNLOCK2;
        seq_data[1] = DATA_UNLOCK2;
        case ($urandom_range(0, 2))
          0: begin
            len = 6;
            seq_data[2] = CMD_ERASE;
            seq_addr[4] = ADDR_UNLOCK2;
            seq_data[4] = DATA_UNLOCK2;
            seq_addr[5] = pick_address();
            seq_data[5] = ($urandom_range(0, 1) == 0) ? CMD_SECTOR : CMD_CHIP;
          end
          1: begin
            len = 4;
            seq_data[2] = CMD_PROGRAM;
            seq_addr[3] = pick_address();
            seq_data[3] = 8'($urandom);
          end
          default: begin
            len = 4;
            seq_data[2] = CMD_BANK;
            seq_addr[3] = 16'h0000;
            seq_data[3] = 8'($urandom);
          end
        endcase
        k = $urandom_range(0, len - 1);
        if ($urandom_range(0, 1) == 0) seq_addr[k] ^= 16'(1 << $urandom_range(0, 15));
        else seq_data[k] ^= 8'(1 << $urandom_range(0, 7));
        last = $urandom_range(k, len - 1);
        for (int i = 0; i <= last; i++) send_word(1'b1, seq_addr[i], defuse(seq_data[i]));
      end else begin
        // raw noise on every field
        repeat ($urandom_range(1, 4)) begin
          send_word(1'($urandom), 16'($urandom), defuse(8'($urandom)));
        end
      end
      // now and then hold the sender until the device has answered everything
      if (gaps_on && $urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  // ------------------------------------------------------------------------
  // Result checking: every out_valid pulse consumes the oldest prediction
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (expected_bytes.size() == 0) begin
        report_failure($sformatf("result word %02h with nothing outstanding",
                                 out_read_data));
      end else begin
        oldest = expected_bytes.pop_front();
        if (out_valid !== 1'b1 || out_read_data !== oldest.data) begin
          report_failure($sformatf("%s at %04h: read_data %02h, want %02h",
                                   oldest.is_write ? "write" : "read", oldest.addr,
                                   out_read_data, oldest.data));
        end
      end
    end
  end

  // Watchdog: count cycles where neither a word nor a result moves
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Sequence of tests
  // ------------------------------------------------------------------------
  initial begin
    // power-up image of the device
    for (int i = 0; i < BANK_COUNT * BANK_SIZE; i++) flash_mem[i] = ERASED_BYTE;
    seq_st    = SEQ_IDLE;
    rd_mode   = RD_ARRAY;
    bank_sel  = 1'b0;
    cfg_large = 1'b0;
    cfg_fill  = 8'h00;

    // hold reset, then release it on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // registers at their reset values for the directed words
    test_power_up_read();
    test_byte_program();
    test_autoselect();
    test_sector_erase();

    program_registers(1'b1, 8'hA5);
    test_two_bank_chip_erase();
    test_random_traffic(390);

    program_registers(1'b0, 8'hFF);
    test_random_traffic(390);

    program_registers(1'b1, 8'h00);
    test_random_traffic(390);

    // last stretch runs back to back
    program_registers(1'b0, 8'($urandom));
    gaps_on = 1'b0;
    test_random_traffic(390);

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/fcs_pkg.sv
rtl/fcs_ctrl.sv
rtl/fcs_datapath.sv
rtl/flash_command_sequencer.sv
dv/flash_command_sequencer_test.sv
